// ===== src/assert_macros.svh =====
// Assertion helpers used by the RTL. Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside of reset.
`define BMM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define BMM_ASSERT_NEXT(label, ante, cons, msg) \
    `BMM_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ===== src/bmm_pkg.sv =====
`default_nettype none

package bmm_pkg;

    // Operation codes.
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_LOAD  = 2'd2;

    // Image-load targets.
    localparam logic [2:0] STORE_RAM    = 3'd0;
    localparam logic [2:0] STORE_BASIC  = 3'd1;
    localparam logic [2:0] STORE_KERNAL = 3'd2;
    localparam logic [2:0] STORE_CHAR   = 3'd3;
    localparam logic [2:0] STORE_IO     = 3'd4;

    // Data source codes.
    localparam logic [2:0] SRC_RAM    = 3'd0;
    localparam logic [2:0] SRC_BASIC  = 3'd1;
    localparam logic [2:0] SRC_KERNAL = 3'd2;
    localparam logic [2:0] SRC_CHAR   = 3'd3;
    localparam logic [2:0] SRC_IO     = 3'd4;
    localparam logic [2:0] SRC_SYNTH  = 3'd5;

    // Synthesized register addresses and the banking latch address.
    localparam logic [15:0] ADDR_CTRL1  = 16'hD011;
    localparam logic [15:0] ADDR_RASTER = 16'hD012;
    localparam logic [15:0] ADDR_KEY_A  = 16'hDC00;
    localparam logic [15:0] ADDR_KEY_B  = 16'hDC01;
    localparam logic [15:0] ADDR_TA_LO  = 16'hDC04;
    localparam logic [15:0] ADDR_TA_HI  = 16'hDC05;
    localparam logic [15:0] ADDR_TB_LO  = 16'hDC06;
    localparam logic [15:0] ADDR_TB_HI  = 16'hDC07;
    localparam logic [15:0] ADDR_ICR    = 16'hDC0D;
    localparam logic [15:0] ADDR_LATCH  = 16'h0001;

    // Register read values.
    localparam logic [7:0] ICR_FIRED = 8'h81;
    localparam logic [7:0] ICR_CLEAR = 8'h00;
    localparam logic [7:0] NO_KEY    = 8'hFF;
    localparam logic [7:0] LOW7      = 8'h7F;

    // Counter limits.
    localparam logic [5:0]  LINE_CYCLES = 6'd63;
    localparam logic [8:0]  LAST_LINE   = 9'd311;
    localparam logic [15:0] TA_TOP      = 16'd16421;
    localparam logic [14:0] TA_PERIOD   = 15'd16422;
    localparam logic [15:0] TB_TOP      = 16'hFFFF;

    // Counter values after this beat's cycles are applied.
    typedef struct packed {
        logic [8:0]  raster_line;
        logic [15:0] timer_a;
        logic [15:0] timer_b;
        logic        fired;
    } tim_t;

endpackage

`default_nettype wire

// ===== src/bmm_ram.sv =====
`default_nettype none

module bmm_ram #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 8
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [DATA_W-1:0] wdata,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [(1 << ADDR_W)];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// ===== src/bmm_timers.sv =====
`default_nettype none

module bmm_timers (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       advance,
    input  wire logic [4:0] cycles,
    input  wire logic       icr_clear,
    output bmm_pkg::tim_t   tim
);

    logic [5:0]  line_cycle_reg;
    logic [5:0]  line_cycle_next;
    logic [8:0]  raster_line_reg;
    logic [8:0]  raster_line_next;
    logic [14:0] ta_phase_reg;
    logic [14:0] ta_phase_next;
    logic [15:0] tb_phase_reg;
    logic [15:0] tb_phase_next;
    logic        underflow_reg;
    logic        underflow_next;
    logic [6:0]  line_sum;
    logic [14:0] ta_sum;
    logic        line_wrap;
    logic        ta_wrap;
    logic        fired;

    always_comb
    begin
        line_sum  = {1'b0, line_cycle_reg} + {2'b0, cycles};
        line_wrap = line_sum >= {1'b0, bmm_pkg::LINE_CYCLES};
        line_cycle_next = line_wrap ? 6'(line_sum - {1'b0, bmm_pkg::LINE_CYCLES})
                                    : line_sum[5:0];
        if (!line_wrap)
        begin
            raster_line_next = raster_line_reg;
        end
        else if (raster_line_reg == bmm_pkg::LAST_LINE)
        begin
            raster_line_next = '0;
        end
        else
        begin
            raster_line_next = raster_line_reg + 9'd1;
        end

        // The phase never exceeds the period plus 31, so 15 bits hold the sum.
        ta_sum        = ta_phase_reg + {10'b0, cycles};
        ta_wrap       = ta_sum >= bmm_pkg::TA_PERIOD;
        ta_phase_next = ta_wrap ? ta_sum - bmm_pkg::TA_PERIOD : ta_sum;
        tb_phase_next = tb_phase_reg + {11'b0, cycles};

        fired          = underflow_reg | ta_wrap;
        underflow_next = fired & ~icr_clear;

        tim.raster_line = raster_line_next;
        tim.timer_a     = bmm_pkg::TA_TOP - {1'b0, ta_phase_next};
        tim.timer_b     = bmm_pkg::TB_TOP - tb_phase_next;
        tim.fired       = fired;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_cycle_reg  <= '0;
            raster_line_reg <= '0;
            ta_phase_reg    <= '0;
            tb_phase_reg    <= '0;
            underflow_reg   <= 1'b0;
        end
        else if (advance)
        begin
            line_cycle_reg  <= line_cycle_next;
            raster_line_reg <= raster_line_next;
            ta_phase_reg    <= ta_phase_next;
            tb_phase_reg    <= tb_phase_next;
            underflow_reg   <= underflow_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/banked_memory_map_with_io.sv =====
// A result strobes on done once its beat has passed the valid_a and done registers.
// Throughput: one beat per cycle; busy stays low, since each store is a
// single-port memory touched once per beat and counters update in that cycle.
// Every beat yields exactly one result, and the receiver cannot stall.
// Reset clears the counters and interrupt flag and sets the bank latch to 7;
// memory contents are undefined until written.
`default_nettype none

`include "assert_macros.svh"

module banked_memory_map_with_io (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  operation,
    input  wire logic [15:0] address,
    input  wire logic [7:0]  write_data,
    input  wire logic [2:0]  image_store,
    input  wire logic [4:0]  cycles_advanced,
    output logic             done,
    output logic [7:0]       read_data,
    output logic [2:0]       data_source
);

    logic          accept;
    logic          is_read;
    logic          is_write;
    logic          is_load;
    logic          lo;
    logic          hi;
    logic          ch;
    logic          in_basic;
    logic          in_dxxx;
    logic          in_kernal;
    logic          io_win;
    logic          icr_clear;
    logic          ram_we;
    logic          basic_we;
    logic          kernal_we;
    logic          char_we;
    logic          io_we;
    logic [2:0]    src;
    logic [7:0]    synth_byte;
    logic          synth_hit;
    logic          ctrl1_hit;
    bmm_pkg::tim_t tim;

    logic [2:0]    bank_latch_reg;
    logic [2:0]    bank_latch_next;

    logic [7:0]    ram_q;
    logic [7:0]    basic_q;
    logic [7:0]    kernal_q;
    logic [7:0]    char_q;
    logic [7:0]    io_q;

    logic          valid_a_reg;
    logic          read_a_reg;
    logic          ctrl1_a_reg;
    logic [2:0]    src_a_reg;
    logic [7:0]    synth_a_reg;

    logic          done_reg;
    logic [7:0]    read_data_reg;
    logic [7:0]    read_data_next;
    logic [2:0]    data_source_reg;
    logic [2:0]    data_source_next;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    assign is_read  = operation == bmm_pkg::OP_READ;
    assign is_write = operation == bmm_pkg::OP_WRITE;
    assign is_load  = operation == bmm_pkg::OP_LOAD;

    assign lo = bank_latch_reg[0];
    assign hi = bank_latch_reg[1];
    assign ch = bank_latch_reg[2];

    assign in_basic  = address[15:13] == 3'b101;
    assign in_dxxx   = address[15:12] == 4'hD;
    assign in_kernal = address[15:13] == 3'b111;
    assign io_win    = in_dxxx & (lo | hi) & ch;

    // Read decode on the banking latch as left by the previous beat.
    always_comb
    begin
        if (in_basic && lo && hi)
        begin
            src = bmm_pkg::SRC_BASIC;
        end
        else if (in_dxxx && (lo || hi))
        begin
            src = ch ? bmm_pkg::SRC_IO : bmm_pkg::SRC_CHAR;
        end
        else if (in_kernal && hi)
        begin
            src = bmm_pkg::SRC_KERNAL;
        end
        else
        begin
            src = bmm_pkg::SRC_RAM;
        end
    end

    always_comb
    begin
        synth_hit  = 1'b1;
        ctrl1_hit  = 1'b0;
        synth_byte = '0;
        case (address)
            bmm_pkg::ADDR_RASTER: synth_byte = tim.raster_line[7:0];
            bmm_pkg::ADDR_CTRL1:
            begin
                // The low seven bits come from the shadow in the next stage.
                ctrl1_hit  = 1'b1;
                synth_byte = {tim.raster_line[8], 7'b0};
            end
            bmm_pkg::ADDR_TA_LO:  synth_byte = tim.timer_a[7:0];
            bmm_pkg::ADDR_TA_HI:  synth_byte = tim.timer_a[15:8];
            bmm_pkg::ADDR_TB_LO:  synth_byte = tim.timer_b[7:0];
            bmm_pkg::ADDR_TB_HI:  synth_byte = tim.timer_b[15:8];
            bmm_pkg::ADDR_KEY_A,
            bmm_pkg::ADDR_KEY_B:  synth_byte = bmm_pkg::NO_KEY;
            bmm_pkg::ADDR_ICR:
                synth_byte = tim.fired ? bmm_pkg::ICR_FIRED : bmm_pkg::ICR_CLEAR;
            default:              synth_hit = 1'b0;
        endcase
    end

    assign icr_clear = is_read & io_win & (address == bmm_pkg::ADDR_ICR);

    bmm_timers u_timers (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (accept),
        .cycles    (cycles_advanced),
        .icr_clear (icr_clear),
        .tim       (tim)
    );

    assign ram_we    = accept & ((is_write & ~io_win)
                     | (is_load & (image_store == bmm_pkg::STORE_RAM)));
    assign io_we     = accept & ((is_write & io_win)
                     | (is_load & (image_store == bmm_pkg::STORE_IO)));
    assign basic_we  = accept & is_load & (image_store == bmm_pkg::STORE_BASIC);
    assign kernal_we = accept & is_load & (image_store == bmm_pkg::STORE_KERNAL);
    assign char_we   = accept & is_load & (image_store == bmm_pkg::STORE_CHAR);

    bmm_ram #(.ADDR_W(16), .DATA_W(8)) u_main_ram (
        .clk (clk), .we (ram_we), .addr (address), .wdata (write_data), .rdata (ram_q)
    );

    bmm_ram #(.ADDR_W(13), .DATA_W(8)) u_basic_rom (
        .clk (clk), .we (basic_we), .addr (address[12:0]), .wdata (write_data),
        .rdata (basic_q)
    );

    bmm_ram #(.ADDR_W(13), .DATA_W(8)) u_kernal_rom (
        .clk (clk), .we (kernal_we), .addr (address[12:0]), .wdata (write_data),
        .rdata (kernal_q)
    );

    bmm_ram #(.ADDR_W(12), .DATA_W(8)) u_char_rom (
        .clk (clk), .we (char_we), .addr (address[11:0]), .wdata (write_data),
        .rdata (char_q)
    );

    bmm_ram #(.ADDR_W(12), .DATA_W(8)) u_io_shadow (
        .clk (clk), .we (io_we), .addr (address[11:0]), .wdata (write_data),
        .rdata (io_q)
    );

    // Any store to RAM byte 1 also loads the banking latch.
    assign bank_latch_next = (ram_we && address == bmm_pkg::ADDR_LATCH) ?
                             write_data[2:0] : bank_latch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_latch_reg <= 3'b111;
            valid_a_reg    <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            bank_latch_reg <= bank_latch_next;
            valid_a_reg    <= accept;
            done_reg       <= valid_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        read_a_reg  <= is_read;
        ctrl1_a_reg <= ctrl1_hit;
        src_a_reg   <= (is_read && src == bmm_pkg::SRC_IO && synth_hit) ?
                       bmm_pkg::SRC_SYNTH : src;
        synth_a_reg <= synth_byte;
    end

    always_comb
    begin
        read_data_next   = '0;
        data_source_next = bmm_pkg::SRC_RAM;
        if (read_a_reg)
        begin
            data_source_next = src_a_reg;
            case (src_a_reg)
                bmm_pkg::SRC_RAM:    read_data_next = ram_q;
                bmm_pkg::SRC_BASIC:  read_data_next = basic_q;
                bmm_pkg::SRC_KERNAL: read_data_next = kernal_q;
                bmm_pkg::SRC_CHAR:   read_data_next = char_q;
                bmm_pkg::SRC_IO:     read_data_next = io_q;
                bmm_pkg::SRC_SYNTH:
                    read_data_next = ctrl1_a_reg ?
                                     (synth_a_reg | (io_q & bmm_pkg::LOW7)) : synth_a_reg;
                default:             read_data_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        read_data_reg   <= read_data_next;
        data_source_reg <= data_source_next;
    end

    assign done        = done_reg;
    assign read_data   = read_data_reg;
    assign data_source = data_source_reg;

    `BMM_ASSERT_NEXT(a_done_follows, valid_a_reg, done_reg, "result beat lost")
    `BMM_ASSERT_NEXT(a_latch_hold, !accept, $stable(bank_latch_reg), "latch moved while idle")
    `BMM_ASSERT(a_src_range, done_reg |-> (data_source_reg <= bmm_pkg::SRC_SYNTH), "bad source")
    `BMM_ASSERT(a_rom_by_load, (basic_we || kernal_we || char_we) |-> is_load, "ROM write")

endmodule

`default_nettype wire

// ===== bench/tb_banked_memory_map_with_io.sv =====
`timescale 1ns / 1ps

module tb_banked_memory_map_with_io;

    // Codes for which the block accepts a beat but writes no store.
    localparam logic [1:0] OP_IDLE    = 2'd3;
    localparam logic [2:0] STORE_NONE = 3'd7;

    localparam int DIRECTED_ROWS = 26;
    localparam int RANDOM_ITEMS  = 674;
    localparam int CYCLE_LIMIT   = 500000;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] addr;
        logic [7:0]  wdata;
        logic [2:0]  store;
        logic [4:0]  cyc;
    } access_t;

    typedef struct packed {
        logic [7:0] data;
        logic [2:0] src;
    } reply_t;

    typedef struct packed {
        access_t acc;
        logic    known;
        reply_t  reply;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  operation;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [2:0]  image_store;
    logic [4:0]  cycles_advanced;
    logic        done;
    logic [7:0]  read_data;
    logic [2:0]  data_source;

    // Shadow of the memory map, with a flag per entry that has been written.
    logic [7:0] ram_img    [65536];
    logic [7:0] basic_img  [8192];
    logic [7:0] kernal_img [8192];
    logic [7:0] char_img   [4096];
    logic [7:0] io_img     [4096];
    bit         ram_set    [65536];
    bit         basic_set  [8192];
    bit         kernal_set [8192];
    bit         char_set   [4096];
    bit         io_set     [4096];

    logic [2:0]  bank_bits;
    int unsigned line_pos;
    int unsigned raster;
    int unsigned ta_phase;
    int unsigned tb_phase;
    bit          ta_fired;

    reply_t reply_q [$];
    reply_t due_reply;
    int     err_count;
    int     cycle_count;
    int     quiet_left;

    dir_row_t directed_rows [DIRECTED_ROWS] = '{
        '{'{bmm_pkg::OP_READ, bmm_pkg::ADDR_ICR, 8'h00, bmm_pkg::STORE_RAM, 5'd0}, 1'b1,
          '{bmm_pkg::ICR_CLEAR, bmm_pkg::SRC_SYNTH}},
        '{'{bmm_pkg::OP_READ, bmm_pkg::ADDR_KEY_A, 8'h00, bmm_pkg::STORE_RAM, 5'd0}, 1'b1,
          '{bmm_pkg::NO_KEY, bmm_pkg::SRC_SYNTH}},
        '{'{bmm_pkg::OP_READ, bmm_pkg::ADDR_KEY_B, 8'h00, bmm_pkg::STORE_RAM, 5'd0}, 1'b1,
          '{bmm_pkg::NO_KEY, bmm_pkg::SRC_SYNTH}},
        '{'{bmm_pkg::OP_READ, bmm_pkg::ADDR_RASTER, 8'h00, bmm_pkg::STORE_RAM, 5'd0}, 1'b1,
          '{8'h00, bmm_pkg::SRC_SYNTH}},
        '{'{bmm_pkg::OP_READ, bmm_pkg::ADDR_TA_LO, 8'h00, bmm_pkg::STORE_RAM, 5'd0}, 1'b1,
          '{8'h25, bmm_pkg::SRC_SYNTH}},
        '{'{bmm_pkg::OP_READ, bmm_pkg::ADDR_TA_HI, 8'h00, bmm_pkg::STORE_RAM, 5'd0}, 1'b1,
          '{8'h40, bmm_pkg::SRC_SYNTH}},
        '{'{bmm_pkg::OP_READ, bmm_pkg::ADDR_TB_LO, 8'h00, bmm_pkg::STORE_RAM, 5'd0}, 1'b1,
          '{8'hFF, bmm_pkg::SRC_SYNTH}},
        '{'{bmm_pkg::OP_READ, bmm_pkg::ADDR_TB_HI, 8'h00, bmm_pkg::STORE_RAM, 5'd0}, 1'b1,
          '{8'hFF, bmm_pkg::SRC_SYNTH}},
        '{'{bmm_pkg::OP_LOAD, 16'h0011, 8'hFF, bmm_pkg::STORE_IO, 5'd0}, 1'b1,
          '{8'h00, bmm_pkg::SRC_RAM}},
        '{'{bmm_pkg::OP_READ, bmm_pkg::ADDR_CTRL1, 8'h00, bmm_pkg::STORE_RAM, 5'd0}, 1'b1,
          '{bmm_pkg::LOW7, bmm_pkg::SRC_SYNTH}},
        '{'{bmm_pkg::OP_LOAD, 16'hFFFF, 8'hA5, bmm_pkg::STORE_BASIC, 5'd31}, 1'b1,
          '{8'h00, bmm_pkg::SRC_RAM}},
        '{'{bmm_pkg::OP_READ, 16'hBFFF, 8'h00, bmm_pkg::STORE_RAM, 5'd1}, 1'b0,
          '{8'h00, bmm_pkg::SRC_RAM}},
        '{'{bmm_pkg::OP_LOAD, 16'h0000, 8'h5A, bmm_pkg::STORE_KERNAL, 5'd0}, 1'b1,
          '{8'h00, bmm_pkg::SRC_RAM}},
        '{'{bmm_pkg::OP_READ, 16'hE000, 8'h00, bmm_pkg::STORE_RAM, 5'd7}, 1'b0,
          '{8'h00, bmm_pkg::SRC_RAM}},
        '{'{bmm_pkg::OP_LOAD, 16'h0FFF, 8'h3C, bmm_pkg::STORE_CHAR, 5'd0}, 1'b1,
          '{8'h00, bmm_pkg::SRC_RAM}},
        '{'{bmm_pkg::OP_WRITE, bmm_pkg::ADDR_LATCH, 8'h03, bmm_pkg::STORE_RAM, 5'd2}, 1'b1,
          '{8'h00, bmm_pkg::SRC_RAM}},
        '{'{bmm_pkg::OP_READ, 16'hDFFF, 8'h00, bmm_pkg::STORE_RAM, 5'd0}, 1'b0,
          '{8'h00, bmm_pkg::SRC_RAM}},
        '{'{bmm_pkg::OP_WRITE, 16'hD020, 8'h77, bmm_pkg::STORE_RAM, 5'd0}, 1'b1,
          '{8'h00, bmm_pkg::SRC_RAM}},
        '{'{bmm_pkg::OP_LOAD, bmm_pkg::ADDR_LATCH, 8'h00, bmm_pkg::STORE_RAM, 5'd0}, 1'b1,
          '{8'h00, bmm_pkg::SRC_RAM}},
        '{'{bmm_pkg::OP_READ, 16'hD020, 8'h00, bmm_pkg::STORE_RAM, 5'd0}, 1'b0,
          '{8'h00, bmm_pkg::SRC_RAM}},
        '{'{bmm_pkg::OP_READ, bmm_pkg::ADDR_LATCH, 8'h00, bmm_pkg::STORE_RAM, 5'd0}, 1'b0,
          '{8'h00, bmm_pkg::SRC_RAM}},
        '{'{OP_IDLE, 16'hFFFF, 8'hFF, STORE_NONE, 5'd31}, 1'b1,
          '{8'h00, bmm_pkg::SRC_RAM}},
        '{'{bmm_pkg::OP_LOAD, 16'hFFFF, 8'hFF, STORE_NONE, 5'd31}, 1'b1,
          '{8'h00, bmm_pkg::SRC_RAM}},
        '{'{bmm_pkg::OP_WRITE, bmm_pkg::ADDR_LATCH, 8'hFF, bmm_pkg::STORE_RAM, 5'd0}, 1'b1,
          '{8'h00, bmm_pkg::SRC_RAM}},
        '{'{bmm_pkg::OP_WRITE, 16'hD400, 8'h00, bmm_pkg::STORE_RAM, 5'd0}, 1'b1,
          '{8'h00, bmm_pkg::SRC_RAM}},
        '{'{bmm_pkg::OP_READ, 16'hD400, 8'h00, bmm_pkg::STORE_RAM, 5'd0}, 1'b0,
          '{8'h00, bmm_pkg::SRC_RAM}}
    };

    banked_memory_map_with_io dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .operation       (operation),
        .address         (address),
        .write_data      (write_data),
        .image_store     (image_store),
        .cycles_advanced (cycles_advanced),
        .done            (done),
        .read_data       (read_data),
        .data_source     (data_source)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Works out which store a CPU read lands in under the current banking.
    // Synthesized registers report STORE_NONE, except the control register,
    // whose low bits come from the I/O shadow.
    function automatic void map_read(input logic [15:0] a, output logic [2:0] src,
                                     output logic [2:0] store);
        logic lo;
        logic hi;
        logic ch;
        lo = bank_bits[0];
        hi = bank_bits[1];
        ch = bank_bits[2];
        src = bmm_pkg::SRC_RAM;
        store = bmm_pkg::STORE_RAM;
        if (a <= 16'h0001)
        begin
            src = bmm_pkg::SRC_RAM;
        end
        else if (a inside {[16'hA000:16'hBFFF]})
        begin
            if (lo && hi)
            begin
                src = bmm_pkg::SRC_BASIC;
                store = bmm_pkg::STORE_BASIC;
            end
        end
        else if (a inside {[16'hD000:16'hDFFF]})
        begin
            if (!lo && !hi)
            begin
                src = bmm_pkg::SRC_RAM;
            end
            else if (!ch)
            begin
                src = bmm_pkg::SRC_CHAR;
                store = bmm_pkg::STORE_CHAR;
            end
            else
            begin
                src = bmm_pkg::SRC_SYNTH;
                store = STORE_NONE;
                case (a)
                    bmm_pkg::ADDR_CTRL1: store = bmm_pkg::STORE_IO;
                    bmm_pkg::ADDR_RASTER, bmm_pkg::ADDR_KEY_A, bmm_pkg::ADDR_KEY_B,
                    bmm_pkg::ADDR_TA_LO, bmm_pkg::ADDR_TA_HI, bmm_pkg::ADDR_TB_LO,
                    bmm_pkg::ADDR_TB_HI, bmm_pkg::ADDR_ICR: store = STORE_NONE;
                    default:
                    begin
                        src = bmm_pkg::SRC_IO;
                        store = bmm_pkg::STORE_IO;
                    end
                endcase
            end
        end
        else if (a >= 16'hE000 && hi)
        begin
            src = bmm_pkg::SRC_KERNAL;
            store = bmm_pkg::STORE_KERNAL;
        end
    endfunction

    function automatic bit is_written(input logic [2:0] store, input logic [15:0] a);
        case (store)
            bmm_pkg::STORE_RAM:    return ram_set[a];
            bmm_pkg::STORE_BASIC:  return basic_set[a[12:0]];
            bmm_pkg::STORE_KERNAL: return kernal_set[a[12:0]];
            bmm_pkg::STORE_CHAR:   return char_set[a[11:0]];
            bmm_pkg::STORE_IO:     return io_set[a[11:0]];
            default:               return 1'b1;
        endcase
    endfunction

    function automatic void poke(input logic [2:0] store, input logic [15:0] a,
                                 input logic [7:0] v);
        case (store)
            bmm_pkg::STORE_RAM:
            begin
                ram_img[a] = v;
                ram_set[a] = 1'b1;
                if (a == bmm_pkg::ADDR_LATCH)
                    bank_bits = v[2:0];
            end
            bmm_pkg::STORE_BASIC:
            begin
                basic_img[a[12:0]] = v;
                basic_set[a[12:0]] = 1'b1;
            end
            bmm_pkg::STORE_KERNAL:
            begin
                kernal_img[a[12:0]] = v;
                kernal_set[a[12:0]] = 1'b1;
            end
            bmm_pkg::STORE_CHAR:
            begin
                char_img[a[11:0]] = v;
                char_set[a[11:0]] = 1'b1;
            end
            bmm_pkg::STORE_IO:
            begin
                io_img[a[11:0]] = v;
                io_set[a[11:0]] = 1'b1;
            end
            default:
            begin
            end
        endcase
    endfunction

    // Advances the counters, performs one bus access and returns its reply.
    function automatic reply_t cpu_bus_step(input access_t acc);
        reply_t      r;
        logic [2:0]  src;
        logic [2:0]  store;
        logic [15:0] timer_a;
        logic [15:0] timer_b;
        logic        to_io;
        r = '0;
        line_pos += acc.cyc;
        if (line_pos >= bmm_pkg::LINE_CYCLES)
        begin
            line_pos -= bmm_pkg::LINE_CYCLES;
            raster++;
            if (raster > bmm_pkg::LAST_LINE)
                raster = 0;
        end
        ta_phase += acc.cyc;
        if (ta_phase >= bmm_pkg::TA_PERIOD)
        begin
            ta_phase -= bmm_pkg::TA_PERIOD;
            ta_fired = 1'b1;
        end
        tb_phase = (tb_phase + acc.cyc) & 32'hFFFF;
        timer_a = bmm_pkg::TA_TOP - 16'(ta_phase);
        timer_b = bmm_pkg::TB_TOP - 16'(tb_phase);

        case (acc.op)
            bmm_pkg::OP_READ:
            begin
                map_read(acc.addr, src, store);
                r.src = src;
                if (src == bmm_pkg::SRC_SYNTH)
                begin
                    case (acc.addr)
                        bmm_pkg::ADDR_RASTER: r.data = raster[7:0];
                        bmm_pkg::ADDR_CTRL1:  r.data = {raster[8], io_img[12'h011][6:0]};
                        bmm_pkg::ADDR_TA_LO:  r.data = timer_a[7:0];
                        bmm_pkg::ADDR_TA_HI:  r.data = timer_a[15:8];
                        bmm_pkg::ADDR_TB_LO:  r.data = timer_b[7:0];
                        bmm_pkg::ADDR_TB_HI:  r.data = timer_b[15:8];
                        bmm_pkg::ADDR_ICR:
                        begin
                            r.data = ta_fired ? bmm_pkg::ICR_FIRED : bmm_pkg::ICR_CLEAR;
                            ta_fired = 1'b0;
                        end
                        default:              r.data = bmm_pkg::NO_KEY;
                    endcase
                end
                else
                begin
                    case (store)
                        bmm_pkg::STORE_BASIC:  r.data = basic_img[acc.addr[12:0]];
                        bmm_pkg::STORE_KERNAL: r.data = kernal_img[acc.addr[12:0]];
                        bmm_pkg::STORE_CHAR:   r.data = char_img[acc.addr[11:0]];
                        bmm_pkg::STORE_IO:     r.data = io_img[acc.addr[11:0]];
                        default:               r.data = ram_img[acc.addr];
                    endcase
                end
            end
            bmm_pkg::OP_WRITE:
            begin
                to_io = acc.addr inside {[16'hD000:16'hDFFF]}
                        && (bank_bits[0] || bank_bits[1]) && bank_bits[2];
                poke(to_io ? bmm_pkg::STORE_IO : bmm_pkg::STORE_RAM, acc.addr, acc.wdata);
            end
            bmm_pkg::OP_LOAD: poke(acc.store, acc.addr, acc.wdata);
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // Addresses cluster around the banking boundaries and the register block,
    // so that reads often hit entries that were written before.
    function automatic logic [15:0] pick_address();
        logic [15:0] regs [10];
        regs = '{bmm_pkg::ADDR_CTRL1, bmm_pkg::ADDR_RASTER, bmm_pkg::ADDR_KEY_A,
                 bmm_pkg::ADDR_KEY_B, bmm_pkg::ADDR_TA_LO, bmm_pkg::ADDR_TA_HI,
                 bmm_pkg::ADDR_TB_LO, bmm_pkg::ADDR_TB_HI, bmm_pkg::ADDR_ICR,
                 bmm_pkg::ADDR_ICR};
        case ($urandom_range(0, 9))
            0:       return 16'($urandom_range(0, 1));
            1:       return 16'($urandom_range(2, 63));
            2:       return ($urandom_range(0, 1) ? 16'hA000 : 16'hBFF0)
                            + 16'($urandom_range(0, 15));
            3:       return 16'hD000 + 16'($urandom_range(0, 63));
            4:       return ($urandom_range(0, 1) ? 16'hDFF0 : 16'hD3F0)
                            + 16'($urandom_range(0, 15));
            5:       return ($urandom_range(0, 1) ? 16'hE000 : 16'hFFF0)
                            + 16'($urandom_range(0, 15));
            6:       return 16'hC000 + 16'($urandom_range(0, 15));
            7, 8:    return regs[$urandom_range(0, 9)];
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic access_t random_access();
        access_t    acc;
        logic [2:0] src;
        logic [2:0] store;
        int         pick;
        pick = $urandom_range(0, 99);
        acc.addr = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535))
                                               : pick_address();
        acc.wdata = 8'($urandom_range(0, 255));
        // Most beats take the largest value of acc.cyc, so within the run timer A
        // underflows and the raster gets past line 255.
        acc.cyc = ($urandom_range(0, 4) != 0) ? 5'd31 : 5'($urandom_range(0, 31));
        acc.store = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                : 3'($urandom_range(0, 4));
        if (pick < 45)
            acc.op = bmm_pkg::OP_READ;
        else if (pick < 70)
            acc.op = bmm_pkg::OP_WRITE;
        else if (pick < 95)
            acc.op = bmm_pkg::OP_LOAD;
        else
            acc.op = OP_IDLE;
        // A read of an entry never written turns into a load of that entry.
        if (acc.op == bmm_pkg::OP_READ)
        begin
            map_read(acc.addr, src, store);
            if (!is_written(store, acc.addr))
            begin
                acc.op = bmm_pkg::OP_LOAD;
                acc.store = store;
            end
        end
        return acc;
    endfunction

    function automatic int next_gap();
        int r;
        if (quiet_left > 0)
        begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0)
            quiet_left = $urandom_range(30, 80);
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Offers one beat after an optional gap and records its reply once taken.
    task automatic send_beat(input access_t acc, input logic known,
                             input reply_t fixed_reply, input int gap);
        reply_t got;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        operation <= acc.op;
        address <= acc.addr;
        write_data <= acc.wdata;
        image_store <= acc.store;
        cycles_advanced <= acc.cyc;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        got = cpu_bus_step(acc);
        reply_q.push_back(known ? fixed_reply : got);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (reply_q.size() == 0)
            begin
                $error("result beat with no access pending");
                err_count++;
            end
            else
            begin
                due_reply = reply_q.pop_front();
                if (read_data !== due_reply.data)
                begin
                    $error("read_data: expected %02h, actual %02h", due_reply.data, read_data);
                    err_count++;
                end
                if (data_source !== due_reply.src)
                begin
                    $error("data_source: expected %0d, actual %0d",
                           due_reply.src, data_source);
                    err_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        access_t acc;
        rst_n = 1'b0;
        start = 1'b0;
        operation = bmm_pkg::OP_READ;
        address = '0;
        write_data = '0;
        image_store = bmm_pkg::STORE_RAM;
        cycles_advanced = '0;
        err_count = 0;
        cycle_count = 0;
        quiet_left = 0;
        bank_bits = 3'd7;
        line_pos = 0;
        raster = 0;
        ta_phase = 0;
        tb_phase = 0;
        ta_fired = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_beat(directed_rows[i].acc, directed_rows[i].known,
                      directed_rows[i].reply, next_gap());

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            acc = random_access();
            send_beat(acc, 1'b0, '0, next_gap());
        end

        start <= 1'b0;
        while (reply_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/bmm_pkg.sv
src/bmm_ram.sv
src/bmm_timers.sv
src/banked_memory_map_with_io.sv
bench/tb_banked_memory_map_with_io.sv
